// ===== hdl/tep_pkg.sv =====
// shared widths, constants and stage payload types of the tanh pipeline
// no dependencies, compile first
package tep_pkg;

    localparam int Z_W    = 16;  // input sample width, q4.12
    localparam int AZ_W   = 17;  // magnitude of the sample, 0..32768
    localparam int KM_W   = 18;  // width of the 2*log2(e) constant
    localparam int A_W    = 33;  // exponent product, q.28
    localparam int K_W    = 5;   // integer part of the exponent
    localparam int F_W    = 24;  // fraction of the exponent, q0.24
    localparam int F_LSB  = 4;   // truncated low bits of the product
    localparam int P_W    = 25;  // polynomial value, q.24 in [1,2)
    localparam int E_W    = 48;  // p shifted by k
    localparam int D_W    = 49;  // divisor e + 1.0
    localparam int N_W    = 64;  // rounded dividend
    localparam int Q_W    = 16;  // quotient bits
    localparam int R_SH   = 15;  // q1.15 scaling of the quotient
    localparam int POLY_N = 6;   // coefficient count, degree 5

    localparam logic [KM_W-1:0] TWO_LOG2E_Q16 = 18'd189097;
    localparam logic [E_W-1:0]  ONE_Q24       = E_W'(1) << F_W;
    localparam logic [Q_W-1:0]  Q_LIMIT       = 16'd32768;
    localparam logic [Z_W-1:0]  MAG_SAT       = 16'd32767;

    // horner coefficients, highest order first, q.24
    localparam logic [P_W-1:0] POLY_COEF [POLY_N] = '{
        25'd22370,
        25'd161365,
        25'd931204,
        25'd4030332,
        25'd11629080,
        25'd16777216
    };

    typedef struct packed {
        logic           neg;
        logic [K_W-1:0] k;
        logic [P_W-1:0] p;
    } t_exp;

    typedef struct packed {
        logic           neg;
        logic [Q_W-1:0] q;
    } t_quot;

endpackage

// ===== hdl/tep_exp.sv =====
// front of the tanh pipeline: magnitude, exponent split and horner 2^f
// depends on tep_pkg
module tep_exp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [tep_pkg::Z_W-1:0] i_z,
    output logic                 o_valid,
    output tep_pkg::t_exp        o_data
);
    import tep_pkg::*;

    localparam int NS = POLY_N;  // one product stage plus one stage per horner step
    localparam logic [AZ_W-1:0] AZ_MOD = AZ_W'(1) << Z_W;

    logic [NS-1:0]      r_v;
    logic [NS-1:0]      r_neg;
    logic [K_W-1:0]     r_k   [NS];
    logic [F_W-1:0]     r_f   [NS-1];
    logic [P_W-1:0]     r_p   [1:NS-1];

    logic               w_neg;
    logic [AZ_W-1:0]    w_az;
    logic [A_W-1:0]     w_a;
    logic [P_W-1:0]     w_pin  [1:NS-1];
    logic [P_W+F_W-1:0] w_prod [1:NS-1];
    logic [P_W:0]       w_sum  [1:NS-1];

    // -32768 maps to a magnitude of 8.0
    assign w_neg = i_z[Z_W-1];
    assign w_az  = w_neg ? (AZ_MOD - {1'b0, i_z}) : {1'b0, i_z};
    assign w_a   = A_W'(w_az) * A_W'(TWO_LOG2E_Q16);

    always_comb begin
        w_pin[1] = POLY_COEF[0];
        for (int h = 2; h < NS; h++) begin
            w_pin[h] = r_p[h-1];
        end
        for (int h = 1; h < NS; h++) begin
            w_prod[h] = {{F_W{1'b0}}, w_pin[h]} * {{P_W{1'b0}}, r_f[h-1]};
            w_sum[h]  = {1'b0, w_prod[h][P_W+F_W-1:F_W]} + {1'b0, POLY_COEF[h]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[NS-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg[0] <= w_neg;
            r_k[0]   <= w_a[A_W-1:A_W-K_W];
            r_f[0]   <= w_a[F_W+F_LSB-1:F_LSB];
            for (int h = 1; h < NS; h++) begin
                r_neg[h] <= r_neg[h-1];
                r_k[h]   <= r_k[h-1];
                r_p[h]   <= w_sum[h][P_W-1:0];
            end
            for (int h = 1; h < NS-1; h++) begin
                r_f[h] <= r_f[h-1];
            end
        end
    end

    assign o_valid    = r_v[NS-1];
    assign o_data.neg = r_neg[NS-1];
    assign o_data.k   = r_k[NS-1];
    assign o_data.p   = r_p[NS-1];

endmodule

// ===== hdl/tep_div.sv =====
// back of the tanh pipeline: 2^k shift, rounded dividend and a
// one-bit-per-stage restoring divider; depends on tep_pkg
module tep_div (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  tep_pkg::t_exp i_data,
    output logic          o_valid,
    output tep_pkg::t_quot o_data
);
    import tep_pkg::*;

    localparam int NQ = Q_W;  // divider stages

    // stage a: e = p << k
    logic               r_va;
    logic               r_nega;
    logic [E_W-1:0]     r_e;
    // stage b: numerator and divisor
    logic               r_vb;
    logic               r_negb;
    logic [E_W-1:0]     r_num;
    logic [D_W-1:0]     r_denb;
    // stage c (index 0) and divider steps 1..NQ
    logic [NQ:0]        r_v;
    logic [NQ:0]        r_neg;
    logic [D_W-1:0]     r_den [NQ];
    logic [D_W-1:0]     r_rem [NQ];
    logic [Q_W-1:0]     r_low [NQ];
    logic [Q_W-1:0]     r_q   [1:NQ];

    logic [E_W-1:0]     w_e;
    logic [N_W-1:0]     w_n;
    logic [Q_W-1:0]     w_qin [1:NQ];
    logic [D_W:0]       w_tr  [1:NQ];
    logic               w_ge  [1:NQ];
    logic [D_W:0]       w_dif [1:NQ];

    assign w_e = E_W'(i_data.p) << i_data.k;
    // (e - 1) * 2^15 + (e + 1) / 2, round half up
    assign w_n = (N_W'(r_num) << R_SH) + N_W'(r_denb >> 1);

    always_comb begin
        w_qin[1] = '0;
        for (int j = 2; j <= NQ; j++) begin
            w_qin[j] = r_q[j-1];
        end
        for (int j = 1; j <= NQ; j++) begin
            w_tr[j]  = {r_rem[j-1], r_low[j-1][Q_W-1]};
            w_ge[j]  = w_tr[j] >= {1'b0, r_den[j-1]};
            w_dif[j] = w_tr[j] - {1'b0, r_den[j-1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_v  <= '0;
        end else if (i_en) begin
            r_va <= i_valid;
            r_vb <= r_va;
            r_v  <= {r_v[NQ-1:0], r_vb};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_nega   <= i_data.neg;
            r_e      <= w_e;
            r_negb   <= r_nega;
            r_num    <= (r_e >= ONE_Q24) ? (r_e - ONE_Q24) : '0;
            r_denb   <= {1'b0, r_e} + {1'b0, ONE_Q24};
            r_neg[0] <= r_negb;
            r_den[0] <= r_denb;
            r_rem[0] <= D_W'(w_n[N_W-1:Q_W]);
            r_low[0] <= w_n[Q_W-1:0];
            for (int j = 1; j <= NQ; j++) begin
                r_neg[j] <= r_neg[j-1];
                r_q[j]   <= {w_qin[j][Q_W-2:0], w_ge[j]};
            end
            for (int j = 1; j < NQ; j++) begin
                r_den[j] <= r_den[j-1];
                r_rem[j] <= w_ge[j] ? w_dif[j][D_W-1:0] : w_tr[j][D_W-1:0];
                r_low[j] <= {r_low[j-1][Q_W-2:0], 1'b0};
            end
        end
    end

    assign o_valid    = r_v[NQ];
    assign o_data.neg = r_neg[NQ];
    assign o_data.q   = r_q[NQ];

endmodule

// ===== hdl/tanh_exp2_poly.sv =====
// tanh of a signed q4.12 sample into signed q1.15, built on tep_exp and tep_div
// depth: 26 register stages counting the output register
// throughput: one transfer per cycle while the skid register is empty, set by the
// one-multiply horner stages and the one-quotient-bit divider stages, all stepping
// together on a common enable
// reset: synchronous active-low i_rst_n empties the pipeline, output and skid register
module tanh_exp2_poly (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // [15:0] z_in, signed q4.12
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata    // [15:0] tanh_out, signed q1.15
);
    import tep_pkg::*;

    // pipeline steps whenever the skid register is empty, so input
    // ready never waits on the output side combinationally
    logic           w_en;
    logic           w_exp_valid;
    t_exp           w_exp;
    logic           w_div_valid;
    t_quot          w_div;
    logic [Z_W-1:0] w_mag;
    logic [Z_W-1:0] w_res;
    logic           w_take;
    logic           w_out_free;

    logic           r_out_valid;
    logic [Z_W-1:0] r_out_data;
    logic           r_sk_valid;
    logic [Z_W-1:0] r_sk_data;
    logic           n_out_valid;
    logic [Z_W-1:0] n_out_data;
    logic           n_sk_valid;
    logic [Z_W-1:0] n_sk_data;

    assign w_en = !r_sk_valid;

    // |z|, exponent split, 2^f by horner
    tep_exp u_exp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_s_axis_tvalid),
        .i_z     (i_s_axis_tdata),
        .o_valid (w_exp_valid),
        .o_data  (w_exp)
    );

    // 2^k shift and rounded (e - 1) / (e + 1)
    tep_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_exp_valid),
        .i_data  (w_exp),
        .o_valid (w_div_valid),
        .o_data  (w_div)
    );

    // +1.0 saturates, then the odd symmetry puts the sign back
    assign w_mag = w_div.q[Q_W-1] ? MAG_SAT : w_div.q;
    assign w_res = w_div.neg ? (Z_W'(0) - w_mag) : w_mag;

    // the last stage is consumed whenever the pipeline steps
    assign w_take     = w_en && w_div_valid;
    assign w_out_free = !r_out_valid || i_m_axis_tready;

    always_comb begin
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        n_sk_valid  = r_sk_valid;
        n_sk_data   = r_sk_data;
        if (w_out_free) begin
            if (r_sk_valid) begin
                // drain the parked result first
                n_out_valid = 1'b1;
                n_out_data  = r_sk_data;
                n_sk_valid  = 1'b0;
            end else begin
                n_out_valid = w_take;
                n_out_data  = w_res;
            end
        end else if (w_take) begin
            // output held, park the arriving result
            n_sk_valid = 1'b1;
            n_sk_data  = w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_sk_valid  <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            r_sk_valid  <= n_sk_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
        r_sk_data  <= n_sk_data;
    end

    assign o_s_axis_tready = w_en;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

`ifndef NO_ASSERTIONS
    // reset leaves nothing to deliver and the input open
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid && o_s_axis_tready)
        else $error("output or skid not empty after reset");

    // skid register only fills behind a held output
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sk_valid |-> r_out_valid)
        else $error("skid register full with output empty");

    // rounded quotient never exceeds 1.0 in q1.15
    a_quot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_valid |-> w_div.q <= Q_LIMIT)
        else $error("divider quotient out of range");

    // saturation and negation never give the most negative code
    a_no_min_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata != 16'h8000)
        else $error("result holds the most negative code");
`endif

endmodule
